>>> rtl/jsv_pkg.sv
// Shared types and character codes for the JSON syntax validator.
// No dependencies; used by jsv_kind_stack, jsv_scan and json_syntax_validator.
package jsv_pkg;

  typedef logic [7:0] byte_t;

  // Command from the scanner to the container stack for one transaction.
  typedef struct packed {
    logic clear;  // document ends: drop every open container
    logic push;   // open a container
    logic pop;    // close the innermost container
    logic kind;   // kind of a pushed container, 1 = object, 0 = array
  } stack_op_t;

  // Status of the container stack as seen by the scanner.
  typedef struct packed {
    logic depth_zero;  // no container is open
    logic depth_one;   // exactly one container is open
    logic full;        // no room for another container
    logic top_obj;     // the innermost container is an object
  } stack_stat_t;

  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_LBRACE = 8'h7B;
  localparam byte_t CH_RBRACE = 8'h7D;
  localparam byte_t CH_LBRACK = 8'h5B;
  localparam byte_t CH_RBRACK = 8'h5D;
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_COLON  = 8'h3A;
  localparam byte_t CH_COMMA  = 8'h2C;
  localparam byte_t CH_MINUS  = 8'h2D;
  localparam byte_t CH_PLUS   = 8'h2B;
  localparam byte_t CH_DOT    = 8'h2E;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_NINE   = 8'h39;
  localparam byte_t CH_LC_E   = 8'h65;
  localparam byte_t CH_UC_E   = 8'h45;
  localparam byte_t CH_LC_T   = 8'h74;
  localparam byte_t CH_LC_F   = 8'h66;
  localparam byte_t CH_LC_N   = 8'h6E;
  localparam byte_t CH_LC_R   = 8'h72;
  localparam byte_t CH_LC_U   = 8'h75;
  localparam byte_t CH_LC_A   = 8'h61;
  localparam byte_t CH_LC_L   = 8'h6C;
  localparam byte_t CH_LC_S   = 8'h73;

endpackage

>>> rtl/json_syntax_validator.sv
// Top level of the streaming JSON syntax validator.
// Depends on jsv_pkg, jsv_scan and jsv_kind_stack.
//
//   channel | direction | tdata                    | tlast      | use
//   s_*     | in        | [7:0] text_byte          | final_byte | document bytes
//   m_*     | out       | [0] doc_valid, [7:1] 0   | (none)     | one verdict per doc
//
// The block takes one byte every cycle while s_tready is high; each
// transaction updates the parse mode and does at most one push or pop on
// the container-kind memory, whose read is hidden by keeping the innermost
// kind in a register and prefetching the level below it. A verdict appears
// in the output register the cycle after the marked byte is accepted. Reset
// (rst, synchronous) returns the parser to the start of a document; the
// stack memory needs no clearing pass. Bytes are accepted while a verdict
// waits unless the output register is full and not being drained.
module json_syntax_validator #(
  parameter int MAX_NESTING = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // final_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] doc_valid, [7:1] zero
);
  import jsv_pkg::*;

  logic        take;
  stack_op_t   op;
  stack_stat_t stat;
  logic        res_take;
  logic        res_valid_doc;
  logic        doc_valid;

  // The output register empties or drains in the same cycle that a new
  // verdict would land in it.
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  jsv_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .text_byte     (s_tdata),
    .final_byte    (s_tlast),
    .stat          (stat),
    .op            (op),
    .res_take      (res_take),
    .res_valid_doc (res_valid_doc)
  );

  jsv_kind_stack #(
    .MAX_NESTING (MAX_NESTING)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      doc_valid <= res_valid_doc;
    end
  end

  assign m_tdata = {7'd0, doc_valid};

endmodule

>>> rtl/jsv_kind_stack.sv
// Stack of open container kinds, held in a synchronous memory.
// Depends on jsv_pkg for the command and status structs.
module jsv_kind_stack #(
  parameter int MAX_NESTING = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  jsv_pkg::stack_op_t   op,
  output jsv_pkg::stack_stat_t stat
);
  import jsv_pkg::*;

  localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam int DW = $clog2(MAX_NESTING + 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NESTING);
  localparam logic [DW-1:0] DEPTH_ONE = DW'(1);
  localparam logic [DW-1:0] DEPTH_TWO = DW'(2);

  // Every pushed kind is written at its own level; the innermost kind is
  // also cached in top_kind, and the level below it is kept prefetched in
  // below_kind so that a pop can take it without waiting for a read.
  logic          kinds [MAX_NESTING];
  logic [DW-1:0] depth;
  logic [DW-1:0] depth_next;
  logic          top_kind;
  logic          below_kind;
  logic [DW-1:0] rd_level;

  always_comb begin
    depth_next = depth;
    if (op.clear) begin
      depth_next = '0;
    end else if (op.push) begin
      depth_next = depth + DEPTH_ONE;
    end else if (op.pop) begin
      depth_next = depth - DEPTH_ONE;
    end
  end

  assign rd_level = depth_next - DEPTH_TWO;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      depth <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push && !op.clear) begin
      kinds[depth[AW-1:0]] <= op.kind;
    end
    if (depth_next >= DEPTH_TWO) begin
      below_kind <= kinds[rd_level[AW-1:0]];
    end
    if (op.push) begin
      top_kind <= op.kind;
    end else if (op.pop) begin
      top_kind <= below_kind;
    end
  end

  assign stat.depth_zero = (depth == '0);
  assign stat.depth_one  = (depth == DEPTH_ONE);
  assign stat.full       = (depth >= DEPTH_MAX);
  assign stat.top_obj    = (depth != '0) && top_kind;

endmodule

>>> rtl/jsv_scan.sv
// Byte scanner: parse mode, literal progress and failure state.
// Depends on jsv_pkg; drives the container stack and the document result.
module jsv_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  jsv_pkg::byte_t       text_byte,
  input  logic                 final_byte,
  input  jsv_pkg::stack_stat_t stat,
  output jsv_pkg::stack_op_t   op,
  output logic                 res_take,
  output logic                 res_valid_doc
);
  import jsv_pkg::*;

  typedef enum logic [4:0] {
    M_TOP, M_VALUE, M_FIRST, M_KEY, M_COLON, M_AFTER, M_STR, M_STR_ESC,
    M_KSTR, M_KSTR_ESC, M_TRUE, M_FALSE, M_NULL, M_N_SIGN, M_N_INT,
    M_N_DOT, M_N_FRAC, M_N_EXP, M_N_EXPSIGN, M_N_EXPD
  } mode_t;

  mode_t      mode;
  logic [2:0] lit;
  logic       failed;

  // Character expected at a given position of a literal word.
  function automatic byte_t lit_char(input mode_t m, input logic [2:0] pos);
    byte_t c;
    c = 8'h00;
    case (m)
      M_TRUE: begin
        case (pos)
          3'd1:    c = CH_LC_R;
          3'd2:    c = CH_LC_U;
          3'd3:    c = CH_LC_E;
          default: c = 8'h00;
        endcase
      end
      M_FALSE: begin
        case (pos)
          3'd1:    c = CH_LC_A;
          3'd2:    c = CH_LC_L;
          3'd3:    c = CH_LC_S;
          3'd4:    c = CH_LC_E;
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd1:    c = CH_LC_U;
          3'd2:    c = CH_LC_L;
          3'd3:    c = CH_LC_L;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  logic       is_ws, is_dig, is_exp, closes;
  logic       bv_ok, bv_push, bv_kind;
  mode_t      bv_mode;
  logic [2:0] bv_lit;
  logic       av_ok, av_pop;
  mode_t      av_mode;
  logic       ok, push, pop, kind;
  mode_t      mode_next;
  logic [2:0] lit_next;
  logic [2:0] lit_len;
  logic       done, depth_after_zero;

  assign is_ws  = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                  (text_byte == CH_LF) || (text_byte == CH_CR);
  assign is_dig = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign is_exp = (text_byte == CH_LC_E) || (text_byte == CH_UC_E);
  assign closes = !stat.depth_zero &&
                  (text_byte == (stat.top_obj ? CH_RBRACE : CH_RBRACK));
  assign lit_len = (mode == M_FALSE) ? 3'd5 : 3'd4;

  // Start of a value.
  always_comb begin
    bv_ok   = 1'b1;
    bv_push = 1'b0;
    bv_kind = 1'b0;
    bv_mode = mode;
    bv_lit  = lit;
    case (text_byte)
      CH_LBRACE, CH_LBRACK: begin
        bv_ok   = !stat.full;
        bv_push = !stat.full;
        bv_kind = (text_byte == CH_LBRACE);
        bv_mode = M_FIRST;
      end
      CH_QUOTE: bv_mode = M_STR;
      CH_LC_T: begin
        bv_mode = M_TRUE;
        bv_lit  = 3'd1;
      end
      CH_LC_F: begin
        bv_mode = M_FALSE;
        bv_lit  = 3'd1;
      end
      CH_LC_N: begin
        bv_mode = M_NULL;
        bv_lit  = 3'd1;
      end
      CH_MINUS: bv_mode = M_N_SIGN;
      default: begin
        bv_ok   = is_dig;
        bv_mode = M_N_INT;
      end
    endcase
  end

  // Byte that follows a finished value.
  always_comb begin
    av_ok   = 1'b0;
    av_pop  = 1'b0;
    av_mode = M_AFTER;
    if (is_ws) begin
      av_ok = 1'b1;
    end else if (stat.depth_zero) begin
      av_ok = 1'b0;
    end else if (text_byte == CH_COMMA) begin
      av_ok   = 1'b1;
      av_mode = stat.top_obj ? M_KEY : M_VALUE;
    end else if (closes) begin
      av_ok  = 1'b1;
      av_pop = 1'b1;
    end
  end

  always_comb begin
    ok        = 1'b1;
    push      = 1'b0;
    pop       = 1'b0;
    kind      = 1'b0;
    mode_next = mode;
    lit_next  = lit;
    case (mode)
      M_TOP, M_VALUE: begin
        if (!is_ws) begin
          ok = bv_ok; push = bv_push; kind = bv_kind;
          mode_next = bv_mode; lit_next = bv_lit;
        end
      end
      M_FIRST: begin
        if (is_ws) begin
          ok = 1'b1;
        end else if (closes) begin
          pop = 1'b1;
          mode_next = M_AFTER;
        end else if (stat.top_obj) begin
          ok = (text_byte == CH_QUOTE);
          mode_next = M_KSTR;
        end else begin
          ok = bv_ok; push = bv_push; kind = bv_kind;
          mode_next = bv_mode; lit_next = bv_lit;
        end
      end
      M_KEY: begin
        if (!is_ws) begin
          ok = (text_byte == CH_QUOTE);
          mode_next = M_KSTR;
        end
      end
      M_COLON: begin
        if (!is_ws) begin
          ok = (text_byte == CH_COLON);
          mode_next = M_VALUE;
        end
      end
      M_STR, M_KSTR: begin
        if (text_byte == CH_QUOTE) begin
          mode_next = (mode == M_KSTR) ? M_COLON : M_AFTER;
        end else if (text_byte == CH_BSLASH) begin
          mode_next = (mode == M_KSTR) ? M_KSTR_ESC : M_STR_ESC;
        end else begin
          ok = (text_byte >= CH_SPACE);
        end
      end
      M_STR_ESC:  mode_next = M_STR;
      M_KSTR_ESC: mode_next = M_KSTR;
      M_TRUE, M_FALSE, M_NULL: begin
        ok = (lit < lit_len) && (text_byte == lit_char(mode, lit));
        if (lit + 3'd1 == lit_len) begin
          lit_next  = 3'd0;
          mode_next = M_AFTER;
        end else begin
          lit_next = lit + 3'd1;
        end
      end
      M_N_SIGN, M_N_DOT, M_N_EXPSIGN: begin
        ok = is_dig;
        mode_next = (mode == M_N_DOT) ? M_N_FRAC :
                    (mode == M_N_SIGN) ? M_N_INT : M_N_EXPD;
      end
      M_N_INT, M_N_FRAC, M_N_EXPD: begin
        if (is_dig) begin
          ok = 1'b1;
        end else if (text_byte == CH_DOT && mode == M_N_INT) begin
          mode_next = M_N_DOT;
        end else if (is_exp && mode != M_N_EXPD) begin
          mode_next = M_N_EXP;
        end else begin
          ok = av_ok; pop = av_pop; mode_next = av_mode;
        end
      end
      M_N_EXP: begin
        if (text_byte == CH_PLUS || text_byte == CH_MINUS) begin
          mode_next = M_N_EXPSIGN;
        end else begin
          ok = is_dig;
          mode_next = M_N_EXPD;
        end
      end
      M_AFTER: begin
        ok = av_ok; pop = av_pop; mode_next = av_mode;
      end
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    done = mode_next inside {M_AFTER, M_N_INT, M_N_FRAC, M_N_EXPD};
    depth_after_zero = (stat.depth_zero && !push) || (stat.depth_one && pop);
  end

  assign op.clear = take && final_byte;
  assign op.push  = take && !failed && ok && push;
  assign op.pop   = take && !failed && ok && pop;
  assign op.kind  = kind;

  assign res_take      = take && final_byte;
  assign res_valid_doc = !failed && ok && done && depth_after_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_TOP;
      lit    <= 3'd0;
      failed <= 1'b0;
    end else if (take) begin
      if (final_byte) begin
        mode   <= M_TOP;
        lit    <= 3'd0;
        failed <= 1'b0;
      end else if (!failed) begin
        if (ok) begin
          mode <= mode_next;
          lit  <= lit_next;
        end else begin
          failed <= 1'b1;
        end
      end
    end
  end

endmodule
